// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OPWW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define OPWW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/opww_pkg.sv =====
// Types, codes and defaults for the OLED page window writer.
// No dependencies.
package opww_pkg;

	localparam int COLUMNS_DEF          = 128;
	localparam int PAGES_DEF            = 8;
	localparam int BUS_BUFFER_BYTES_DEF = 32;
	// power of two
	localparam int QUEUE_DEPTH          = 4;

	localparam logic [1:0] REG_WIN_X      = 2'd0;
	localparam logic [1:0] REG_WIN_Y      = 2'd1;
	localparam logic [1:0] REG_WIN_WIDTH  = 2'd2;
	localparam logic [1:0] REG_WIN_HEIGHT = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_EARLY   = 2'd2;
	localparam logic [1:0] ST_OVERRUN = 2'd3;

	localparam logic [7:0] CTRL_CMD   = 8'h80;
	localparam logic [7:0] CTRL_DATA  = 8'h40;
	localparam logic [7:0] CMD_PAGE   = 8'hB0;
	localparam logic [7:0] CMD_COL_LO = 8'h00;
	localparam logic [7:0] CMD_COL_HI = 8'h10;

	typedef enum logic [1:0] {
		HDR_NONE,
		HDR_COL,
		HDR_PAGE
	} opww_hdr_t;

	typedef enum logic [2:0] {
		STEP_PAGE_CTRL,
		STEP_PAGE_ADDR,
		STEP_COLLO_CTRL,
		STEP_COLLO,
		STEP_COLHI_CTRL,
		STEP_COLHI,
		STEP_DATA_CTRL,
		STEP_DATA
	} opww_step_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       data_end;
		logic [1:0] status;
		opww_hdr_t  hdr;
		logic [6:0] column;
		logic [2:0] page;
	} opww_op_t;

endpackage

// ===== hw/rtl/oled_page_window_writer_core.sv =====
// Channel   Dir  Handshake             Payload
// in        in   in_valid / in_stall   pixel_byte, final_byte
// out       out  out_valid / out_stall bus_byte, frame_end, run_last, status
// cfg       in   cfg_we                cfg_index, cfg_data
//
// One bus byte per cycle from the back end while an op is queued and the output
// is not stalled; an item yields 1 to 8 bytes. The front end takes an item per
// cycle until the 4-entry op queue fills. Asynchronous reset restores the full-panel window.
// A stalled output holds its byte; the front keeps accepting until the queue is full.
// Depends on opww_pkg, opww_front, opww_queue, opww_back.
module oled_page_window_writer_core #(
	parameter int COLUMNS          = opww_pkg::COLUMNS_DEF,
	parameter int PAGES            = opww_pkg::PAGES_DEF,
	parameter int BUS_BUFFER_BYTES = opww_pkg::BUS_BUFFER_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] pixel_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] bus_byte,
	output logic       frame_end,
	output logic       run_last,
	output logic [1:0] status
);

	opww_pkg::opww_op_t push_op;
	opww_pkg::opww_op_t head;
	logic push;
	logic pop;
	logic q_empty;
	logic q_full;

	opww_front #(
		.COLUMNS(COLUMNS),
		.PAGES(PAGES),
		.BUS_BUFFER_BYTES(BUS_BUFFER_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.pixel_byte(pixel_byte),
		.final_byte(final_byte),
		.q_full(q_full),
		.in_stall(in_stall),
		.push(push),
		.op(push_op)
	);

	opww_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_op(push_op),
		.pop(pop),
		.head(head),
		.empty(q_empty),
		.full(q_full)
	);

	opww_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(q_empty),
		.head(head),
		.pop(pop),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.bus_byte(bus_byte),
		.frame_end(frame_end),
		.run_last(run_last),
		.status(status)
	);

endmodule

// ===== hw/rtl/opww_front.sv =====
// Front end: window registers, window check, position tracking, op classification.
// Depends on opww_pkg.
module opww_front #(
	parameter int COLUMNS          = opww_pkg::COLUMNS_DEF,
	parameter int PAGES            = opww_pkg::PAGES_DEF,
	parameter int BUS_BUFFER_BYTES = opww_pkg::BUS_BUFFER_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              in_valid,
	input  logic [7:0]        pixel_byte,
	input  logic              final_byte,
	input  logic              q_full,
	output logic              in_stall,
	output logic              push,
	output opww_pkg::opww_op_t op
);

	localparam logic [8:0] COL_LIMIT = 9'(COLUMNS);
	localparam logic [7:0] ROW_LIMIT = 8'(PAGES * 8);
	localparam logic [7:0] CHUNK_MAX = 8'(BUS_BUFFER_BYTES - 1);

	logic [6:0] win_x_q;
	logic [5:0] win_y_q;
	logic [7:0] win_width_q;
	logic [6:0] win_height_q;
	logic [6:0] cur_col_q;
	logic [2:0] cur_page_q;
	logic [7:0] chunk_left_q;
	logic       done_q;

	logic [8:0] x_sum;
	logic [7:0] y_sum;
	logic       win_ok;
	logic [6:0] col_end;
	logic [2:0] page_end;
	logic [7:0] room;
	logic [7:0] chunk;
	logic [7:0] left_new;
	logic       new_chunk;
	logic       row_end;
	logic       last_of_window;
	logic [6:0] rs_x;
	logic [5:0] rs_y;

	assign x_sum = {2'b00, win_x_q} + {1'b0, win_width_q};
	assign y_sum = {2'b00, win_y_q} + {1'b0, win_height_q};
	assign win_ok = (win_y_q[2:0] == 3'd0) && (win_height_q[2:0] == 3'd0) &&
		(win_height_q != 7'd0) && (win_width_q != 8'd0) &&
		(y_sum <= ROW_LIMIT) && (x_sum <= COL_LIMIT);
	assign col_end  = 7'(x_sum - 9'd1);
	assign page_end = 3'((y_sum >> 3) - 8'd1);

	assign room      = {1'b0, col_end} - {1'b0, cur_col_q} + 8'd1;
	assign chunk     = (room < CHUNK_MAX) ? room : CHUNK_MAX;
	assign new_chunk = (chunk_left_q == 8'd0);
	assign left_new  = (new_chunk ? chunk : chunk_left_q) - 8'd1;
	assign row_end   = (cur_col_q >= col_end);
	assign last_of_window = (cur_col_q == col_end) && (cur_page_q == page_end);

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		op.pixel    = 8'd0;
		op.data_end = 1'b0;
		op.status   = opww_pkg::ST_OK;
		op.hdr      = opww_pkg::HDR_NONE;
		op.column   = cur_col_q;
		op.page     = cur_page_q;
		if (!win_ok) begin
			op.status = opww_pkg::ST_INVALID;
		end else if (done_q) begin
			op.status = opww_pkg::ST_OVERRUN;
		end else begin
			op.pixel    = pixel_byte;
			op.data_end = (left_new == 8'd0) || final_byte;
			if (new_chunk) begin
				op.hdr = (cur_col_q == win_x_q) ? opww_pkg::HDR_PAGE : opww_pkg::HDR_COL;
			end
			if (final_byte && !last_of_window) begin
				op.status = opww_pkg::ST_EARLY;
			end
		end
	end

	// restart position after a register write uses the written value
	always_comb begin
		rs_x = win_x_q;
		rs_y = win_y_q;
		if (cfg_index == opww_pkg::REG_WIN_X) begin
			rs_x = cfg_data[6:0];
		end
		if (cfg_index == opww_pkg::REG_WIN_Y) begin
			rs_y = cfg_data[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_x_q      <= 7'd0;
			win_y_q      <= 6'd0;
			win_width_q  <= 8'd128;
			win_height_q <= 7'd64;
			cur_col_q    <= 7'd0;
			cur_page_q   <= 3'd0;
			chunk_left_q <= 8'd0;
			done_q       <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				opww_pkg::REG_WIN_X:      win_x_q      <= cfg_data[6:0];
				opww_pkg::REG_WIN_Y:      win_y_q      <= cfg_data[5:0];
				opww_pkg::REG_WIN_WIDTH:  win_width_q  <= cfg_data;
				opww_pkg::REG_WIN_HEIGHT: win_height_q <= cfg_data[6:0];
				default: ;
			endcase
			cur_col_q    <= rs_x;
			cur_page_q   <= rs_y[5:3];
			chunk_left_q <= 8'd0;
			done_q       <= 1'b0;
		end else if (push && win_ok) begin
			if (final_byte) begin
				cur_col_q    <= win_x_q;
				cur_page_q   <= win_y_q[5:3];
				chunk_left_q <= 8'd0;
				done_q       <= 1'b0;
			end else if (!done_q) begin
				if (row_end) begin
					cur_col_q    <= win_x_q;
					chunk_left_q <= 8'd0;
					if (cur_page_q >= page_end) begin
						done_q <= 1'b1;
					end else begin
						cur_page_q <= cur_page_q + 3'd1;
					end
				end else begin
					cur_col_q    <= cur_col_q + 7'd1;
					chunk_left_q <= left_new;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/opww_queue.sv =====
// Short op queue between front and back ends.
// Depends on opww_pkg.
module opww_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  opww_pkg::opww_op_t push_op,
	input  logic              pop,
	output opww_pkg::opww_op_t head,
	output logic              empty,
	output logic              full
);

	localparam int PW = $clog2(opww_pkg::QUEUE_DEPTH);

	opww_pkg::opww_op_t entry_q [opww_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (PW+1)'(opww_pkg::QUEUE_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PW+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PW+1)'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/opww_back.sv =====
// Back end: expands queued ops into bus bytes, one per cycle unless the output stalls, into an output register.
// Depends on opww_pkg.
module opww_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	input  opww_pkg::opww_op_t head,
	output logic              pop,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [7:0]        bus_byte,
	output logic              frame_end,
	output logic              run_last,
	output logic [1:0]        status
);

	opww_pkg::opww_step_t step_q;
	opww_pkg::opww_step_t step_d;
	opww_pkg::opww_step_t eff;
	logic busy_q;
	logic busy_d;
	logic out_free;
	logic emit;
	logic last_step;
	logic [7:0] byte_d;
	logic end_d;

	assign out_free  = !out_valid || !out_stall;
	assign emit      = !q_empty && out_free;
	assign last_step = (eff == opww_pkg::STEP_DATA);
	assign pop       = emit && last_step;

	always_comb begin
		if (busy_q) begin
			eff = step_q;
		end else begin
			unique case (head.hdr)
				opww_pkg::HDR_PAGE: eff = opww_pkg::STEP_PAGE_CTRL;
				opww_pkg::HDR_COL:  eff = opww_pkg::STEP_COLLO_CTRL;
				default:            eff = opww_pkg::STEP_DATA;
			endcase
		end
	end

	always_comb begin
		byte_d = opww_pkg::CTRL_CMD;
		end_d  = 1'b0;
		unique case (eff)
			opww_pkg::STEP_PAGE_ADDR: begin
				byte_d = opww_pkg::CMD_PAGE | {5'd0, head.page};
				end_d  = 1'b1;
			end
			opww_pkg::STEP_COLLO: begin
				byte_d = opww_pkg::CMD_COL_LO | {4'd0, head.column[3:0]};
				end_d  = 1'b1;
			end
			opww_pkg::STEP_COLHI: begin
				byte_d = opww_pkg::CMD_COL_HI | {5'd0, head.column[6:4]};
				end_d  = 1'b1;
			end
			opww_pkg::STEP_DATA_CTRL: byte_d = opww_pkg::CTRL_DATA;
			opww_pkg::STEP_DATA: begin
				byte_d = head.pixel;
				end_d  = head.data_end;
			end
			default: ;
		endcase
	end

	always_comb begin
		busy_d = busy_q;
		step_d = step_q;
		if (emit) begin
			busy_d = !last_step;
			step_d = opww_pkg::opww_step_t'(3'(eff + 3'd1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= opww_pkg::STEP_PAGE_CTRL;
		end else begin
			busy_q <= busy_d;
			step_q <= step_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			bus_byte  <= byte_d;
			frame_end <= end_d;
			run_last  <= last_step;
			status    <= head.status;
		end
	end

endmodule

// ===== hw/rtl/opww_checker.sv =====
// Port-level checks for the OLED page window writer, bound to the top level.
// Depends on assert_macros.svh and opww_pkg.
`include "assert_macros.svh"

module opww_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] bus_byte,
	input logic       frame_end,
	input logic       run_last,
	input logic [1:0] status
);

	`OPWW_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(bus_byte) && $stable(frame_end) && $stable(status))
	`OPWW_ASSERT_IMPL(a_err_single, clk, arst_n, out_valid && (status == opww_pkg::ST_INVALID || status == opww_pkg::ST_OVERRUN), run_last && !frame_end && bus_byte == 8'd0)
	`OPWW_ASSERT_IMPL(a_early_close, clk, arst_n, out_valid && run_last && status == opww_pkg::ST_EARLY, frame_end)

endmodule

bind oled_page_window_writer_core opww_checker u_opww_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.bus_byte(bus_byte),
	.frame_end(frame_end),
	.run_last(run_last),
	.status(status)
);
